>>> rtl/vcc_pkg.sv
// vcc_pkg: shared types and constants for the vco capacitor calibration block
// no dependencies; used by vcc_core and vco_cap_calibration

package vcc_pkg;

    localparam int CapW = 6;
    localparam int VW   = 2;

    localparam logic [CapW-1:0] CAP_START = 6'd31;
    localparam logic [CapW-1:0] CAP_MAX   = 6'd63;
    localparam logic [CapW-1:0] CAP_MIN   = 6'd0;

    // comparator codes taken from reading bits 7:6
    localparam logic [VW-1:0] V_ZERO  = 2'd0;
    localparam logic [VW-1:0] V_ONE   = 2'd1;
    localparam logic [VW-1:0] V_TWO   = 2'd2;

    // item modes
    localparam logic MODE_START = 1'b0;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_INVALID = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_DEC2A  = 3'd2,
        PH_WAIT31 = 3'd3,
        PH_INC1   = 3'd4,
        PH_DEC0   = 3'd5,
        PH_DEC2B  = 3'd6,
        PH_INC0   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [CapW-1:0] cap_value;
        logic            write_cap;
        status_t         status;
    } result_t;

endpackage

>>> rtl/vcc_core.sv
// vcc_core: calibration state (phase, cap, low mark) and the per-reading step logic
// depends on vcc_pkg

module vcc_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     mode,
    input  logic [vcc_pkg::VW-1:0]   v,
    output vcc_pkg::result_t         result
);

    vcc_pkg::phase_t             phase_reg, phase_next;
    logic [vcc_pkg::CapW-1:0]    cap_reg, cap_next;
    logic [vcc_pkg::CapW-1:0]    low_reg, low_next;

    // state registers, updated once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= vcc_pkg::PH_IDLE;
            cap_reg   <= vcc_pkg::CAP_MIN;
            low_reg   <= vcc_pkg::CAP_MIN;
        end else if (en) begin
            phase_reg <= phase_next;
            cap_reg   <= cap_next;
            low_reg   <= low_next;
        end
    end

    // one step of the search; later searches may run on the same reading
    always_comb begin
        logic       go_dec2a, go_dec0, go_inc0, go_dec2b, go_inc1;
        logic       at_min, at_max;
        logic [7:0] fin_sum;

        go_dec2a = 1'b0;
        go_dec0  = 1'b0;
        go_inc0  = 1'b0;
        go_dec2b = 1'b0;
        go_inc1  = 1'b0;
        at_min   = (cap_reg == vcc_pkg::CAP_MIN);
        at_max   = (cap_reg == vcc_pkg::CAP_MAX);
        fin_sum  = 8'd0;

        phase_next = phase_reg;
        cap_next   = cap_reg;
        low_next   = low_reg;

        if (mode == vcc_pkg::MODE_START) begin
            phase_next = vcc_pkg::PH_FIRST;
            cap_next   = vcc_pkg::CAP_START;
        end else begin
            unique case (phase_reg)
                vcc_pkg::PH_IDLE: begin
                    phase_next = vcc_pkg::PH_IDLE;
                end
                vcc_pkg::PH_FIRST: begin
                    priority if (v == vcc_pkg::V_ZERO) begin
                        go_dec2a = 1'b1;
                    end else if (v == vcc_pkg::V_ONE) begin
                        go_dec0 = 1'b1;
                    end else if (v == vcc_pkg::V_TWO) begin
                        go_inc0 = 1'b1;
                    end else begin
                        phase_next = vcc_pkg::PH_IDLE;
                    end
                end
                vcc_pkg::PH_DEC2A:  go_dec2a = 1'b1;
                vcc_pkg::PH_WAIT31: go_inc1  = 1'b1;
                vcc_pkg::PH_INC1:   go_inc1  = 1'b1;
                vcc_pkg::PH_DEC0:   go_dec0  = 1'b1;
                vcc_pkg::PH_DEC2B:  go_dec2b = 1'b1;
                vcc_pkg::PH_INC0:   go_inc0  = 1'b1;
            endcase
        end

        // down search for the low mark, then restart at 31
        if (go_dec2a) begin
            if (v != vcc_pkg::V_TWO && !at_min) begin
                cap_next   = cap_reg - 6'd1;
                phase_next = vcc_pkg::PH_DEC2A;
            end else begin
                low_next   = cap_reg;
                cap_next   = vcc_pkg::CAP_START;
                phase_next = vcc_pkg::PH_WAIT31;
            end
        end

        // down search for the low mark, falls into the second down search
        if (go_dec0) begin
            if (v != vcc_pkg::V_ZERO && !at_min) begin
                cap_next   = cap_reg - 6'd1;
                phase_next = vcc_pkg::PH_DEC0;
            end else begin
                low_next = cap_reg;
                go_dec2b = 1'b1;
            end
        end

        // up search for the low mark, falls into the second up search
        if (go_inc0) begin
            if (v != vcc_pkg::V_ZERO && !at_max) begin
                cap_next   = cap_reg + 6'd1;
                phase_next = vcc_pkg::PH_INC0;
            end else begin
                low_next = cap_reg;
                go_inc1  = 1'b1;
            end
        end

        // final value (3*high + low + 2) / 4
        fin_sum = {1'b0, cap_reg, 1'b0} + {2'b00, cap_reg} + {2'b00, low_next} + 8'd2;

        // high mark searches
        if (go_dec2b || go_inc1) begin
            if (go_dec2b && v != vcc_pkg::V_TWO && !at_min) begin
                cap_next   = cap_reg - 6'd1;
                phase_next = vcc_pkg::PH_DEC2B;
            end else if (go_inc1 && v != vcc_pkg::V_ONE && !at_max) begin
                cap_next   = cap_reg + 6'd1;
                phase_next = vcc_pkg::PH_INC1;
            end else begin
                cap_next   = fin_sum[7:2];
                phase_next = vcc_pkg::PH_IDLE;
            end
        end
    end

    // result fields: every step writes the new cap except idle readings and a bad first one
    always_comb begin
        logic idle_read, bad_first;

        idle_read = (mode != vcc_pkg::MODE_START) && (phase_reg == vcc_pkg::PH_IDLE);
        bad_first = (mode != vcc_pkg::MODE_START) && (phase_reg == vcc_pkg::PH_FIRST) &&
                    (phase_next == vcc_pkg::PH_IDLE);

        result.write_cap = !(idle_read || bad_first);
        result.cap_value = result.write_cap ? cap_next : vcc_pkg::CAP_MIN;

        priority if (idle_read) begin
            result.status = vcc_pkg::ST_IGNORED;
        end else if (bad_first) begin
            result.status = vcc_pkg::ST_INVALID;
        end else if (phase_next == vcc_pkg::PH_IDLE) begin
            result.status = vcc_pkg::ST_DONE;
        end else begin
            result.status = vcc_pkg::ST_BUSY;
        end
    end

`ifndef ASSERT_OFF
    // a start transaction always leads to the first-reading phase at cap 31
    a_start_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && mode == vcc_pkg::MODE_START) |=>
            (phase_reg == vcc_pkg::PH_FIRST && cap_reg == vcc_pkg::CAP_START))
        else $error("start did not enter first phase at cap 31");

    // a reading while idle leaves the whole state alone
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && mode != vcc_pkg::MODE_START && phase_reg == vcc_pkg::PH_IDLE) |=>
            (phase_reg == vcc_pkg::PH_IDLE && $stable(cap_reg) && $stable(low_reg)))
        else $error("idle reading changed state");

    // done and error results return to idle; only done or in-progress write the cap
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && (result.status == vcc_pkg::ST_DONE || result.status == vcc_pkg::ST_INVALID))
            |=> (phase_reg == vcc_pkg::PH_IDLE))
        else $error("calibration end did not return to idle");

    a_write_status: assert property (@(posedge aclk) disable iff (!aresetn)
        en |-> (result.write_cap ==
            (result.status == vcc_pkg::ST_BUSY || result.status == vcc_pkg::ST_DONE)))
        else $error("cap write flag disagrees with status");
`endif

endmodule

>>> rtl/vco_cap_calibration.sv
// vco_cap_calibration: top level with input register, step core and result register
// depends on vcc_pkg and vcc_core
//
//   channel   ports                                   direction
//   s_        s_valid s_ready s_mode s_vtune_reading  in, one reading or start
//   m_        m_valid m_ready m_cap_value m_write_cap m_status  out, one result
//
// one transaction in gives one result out, through the input register and then the result register
// a new transaction can be taken every cycle while m_ready is high; the step core sits between the regs
// aresetn (synchronous) clears both stage valids and returns the sequencer to idle
// while m_ready is low the result holds and at most one more transaction is taken

module vco_cap_calibration (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [7:0] s_vtune_reading,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_cap_value,
    output logic       m_write_cap,
    output logic [1:0] m_status
);

    logic                         in_valid_reg;
    logic                         in_mode_reg;
    logic [vcc_pkg::VW-1:0]       in_v_reg;
    logic                         out_valid_reg;
    vcc_pkg::result_t             out_res_reg;
    vcc_pkg::result_t             step_res;
    logic                         advance;

    // the held item moves on when the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register: keep only the comparator bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_v_reg    <= s_vtune_reading[7:6];
        end
    end

    vcc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .mode    (in_mode_reg),
        .v       (in_v_reg),
        .result  (step_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_cap_value = out_res_reg.cap_value;
    assign m_write_cap = out_res_reg.write_cap;
    assign m_status    = out_res_reg.status;

endmodule
